### hdl/fan_level_hysteresis_table_macros.svh
// Assertion macros shared by the fan level hysteresis table design.
`ifndef FAN_LEVEL_HYSTERESIS_TABLE_MACROS_SVH
`define FAN_LEVEL_HYSTERESIS_TABLE_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define FLHT_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define FLHT_ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/fhyst_pkg.sv
// Package with the level table, widths and shared types of the fan level controller.
package fhyst_pkg;

   localparam int LEVEL_COUNT = 7;
   localparam int TABLE_ROWS  = 7;
   localparam int TEMP_W      = 9;
   localparam int RPM_W       = 13;
   localparam int LEVEL_OUT_W = 3;
   localparam int LVL_W       = $clog2(LEVEL_COUNT + 1);
   localparam int ROW_W       = $clog2(TABLE_ROWS);

   // Index 0 is the fan zone, 1 the SoC and 2 the charger.
   typedef logic [2:0][TEMP_W-1:0] temp_vec_type;
   typedef logic [ROW_W-1:0]       row_type;
   typedef logic [LVL_W-1:0]       level_type;

   typedef struct packed {
      logic [2:0] lt;
      logic [2:0] gt;
   } cmp_res_type;

   function automatic temp_vec_type mk_vec(input int fz, input int soc, input int chg);
      temp_vec_type v;
      v[0] = TEMP_W'(fz);
      v[1] = TEMP_W'(soc);
      v[2] = TEMP_W'(chg);
      return v;
   endfunction

   // Levels beyond the last table row reuse that row.
   function automatic row_type row_sel(input level_type lvl);
      row_type r;
      if (int'(lvl) < TABLE_ROWS) begin
         r = ROW_W'(lvl);
      end else begin
         r = ROW_W'(TABLE_ROWS - 1);
      end
      return r;
   endfunction

   function automatic temp_vec_type row_on(input row_type r);
      temp_vec_type v;
      case (r)
         3'd0: v = mk_vec(53, 51, 0);
         3'd1: v = mk_vec(54, 52, 0);
         3'd2: v = mk_vec(55, 53, 0);
         3'd3: v = mk_vec(56, 54, 0);
         3'd4: v = mk_vec(57, 55, 54);
         3'd5: v = mk_vec(58, 56, 60);
         default: v = mk_vec(100, 100, 100);
      endcase
      return v;
   endfunction

   function automatic temp_vec_type row_off(input row_type r);
      temp_vec_type v;
      case (r)
         3'd0: v = mk_vec(99, 99, 99);
         3'd1: v = mk_vec(52, 50, 99);
         3'd2: v = mk_vec(53, 51, 99);
         3'd3: v = mk_vec(54, 52, 99);
         3'd4: v = mk_vec(55, 53, 51);
         3'd5: v = mk_vec(56, 54, 52);
         default: v = mk_vec(57, 59, 58);
      endcase
      return v;
   endfunction

   function automatic logic [RPM_W-1:0] row_rpm(input row_type r);
      logic [RPM_W-1:0] v;
      case (r)
         3'd0: v = RPM_W'(0);
         3'd1: v = RPM_W'(3000);
         3'd2: v = RPM_W'(3400);
         3'd3: v = RPM_W'(3800);
         3'd4: v = RPM_W'(4100);
         3'd5: v = RPM_W'(4400);
         default: v = RPM_W'(4900);
      endcase
      return v;
   endfunction

endpackage

### hdl/fhyst_cmp.sv
// Shared signed compare unit: three temperatures against three operands.
module fhyst_cmp (
   input  fhyst_pkg::temp_vec_type temps,
   input  fhyst_pkg::temp_vec_type operand,
   output fhyst_pkg::cmp_res_type  res
);
   import fhyst_pkg::*;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         res.lt[k] = $signed(temps[k]) < $signed(operand[k]);
         res.gt[k] = $signed(temps[k]) > $signed(operand[k]);
      end
   end

endmodule

### hdl/fan_level_hysteresis_table.sv
// Fan level controller: rsp_valid rises once a powered word is accepted and its update is done.
// The direction step finds the direction, then the level moves one table row per cycle
// through a single compare unit (at most 7 rows, then the stopping check).
// A new word is taken only in the idle state, so the next powered word waits until this one is done,
// and longer while an older result word waits unread. An unpowered word starts no update and gives no result.
// Synchronous reset puts the level and the stored previous temperatures to zero.
`include "fan_level_hysteresis_table_macros.svh"

module fan_level_hysteresis_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_system_powered,
   input  logic                               req_fan_index,
   input  logic signed [fhyst_pkg::TEMP_W-1:0] req_temp_fan_zone,
   input  logic signed [fhyst_pkg::TEMP_W-1:0] req_temp_soc,
   input  logic signed [fhyst_pkg::TEMP_W-1:0] req_temp_charger,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_target_fan_index,
   output logic [fhyst_pkg::RPM_W-1:0]        rsp_rpm_target,
   output logic [fhyst_pkg::LEVEL_OUT_W-1:0]  rsp_fan_level
);
   import fhyst_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIR  = 4'b0010,
      ST_WALK = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   level_type        level_ff, level_in;
   temp_vec_type     prev_ff, prev_in;
   temp_vec_type     temps_ff, temps_in;
   logic             idx_ff, idx_in;
   logic             down_ff, down_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_idx_ff, rsp_idx_in;
   logic [RPM_W-1:0] rsp_rpm_ff, rsp_rpm_in;
   logic [LEVEL_OUT_W-1:0] rsp_level_ff, rsp_level_in;

   temp_vec_type operand;
   cmp_res_type  cmp;
   row_type      row;
   level_type    lvl_clamp;

   fhyst_cmp u_cmp (
      .temps   (temps_ff),
      .operand (operand),
      .res     (cmp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign row       = row_sel(level_ff);
   assign lvl_clamp = (int'(level_ff) >= LEVEL_COUNT) ? LVL_W'(LEVEL_COUNT - 1) : level_ff;

   // The direction check compares against the stored sample; the walk against the table.
   always_comb begin
      if (state_ff == ST_DIR) begin
         operand = prev_ff;
      end else if (down_ff) begin
         operand = row_off(row);
      end else begin
         operand = row_on(row);
      end
   end

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      prev_in      = prev_ff;
      temps_in     = temps_ff;
      idx_in       = idx_ff;
      down_in      = down_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_rpm_in   = rsp_rpm_ff;
      rsp_level_in = rsp_level_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_system_powered) begin
               temps_in[0] = req_temp_fan_zone;
               temps_in[1] = req_temp_soc;
               temps_in[2] = req_temp_charger;
               idx_in      = req_fan_index;
               state_in    = ST_DIR;
            end
         end
         ST_DIR: begin
            if (|cmp.lt) begin
               down_in  = 1'b1;
               state_in = ST_WALK;
            end else if (|cmp.gt) begin
               down_in  = 1'b0;
               state_in = ST_WALK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WALK: begin
            if (down_ff) begin
               if ((level_ff != '0) && (&cmp.lt)) begin
                  level_in = level_ff - 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               if ((int'(level_ff) < LEVEL_COUNT) &&
                   ((cmp.gt[0] && cmp.gt[2]) || cmp.gt[1])) begin
                  level_in = level_ff + 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // Wait here only while an older result word is still unread.
            if (!rsp_valid_ff || rsp_ready) begin
               level_in     = lvl_clamp;
               prev_in      = temps_ff;
               rsp_valid_in = 1'b1;
               rsp_idx_in   = idx_ff;
               rsp_rpm_in   = row_rpm(row_sel(lvl_clamp));
               rsp_level_in = LEVEL_OUT_W'(lvl_clamp);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      temps_ff     <= temps_in;
      idx_ff       <= idx_in;
      down_ff      <= down_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_rpm_ff   <= rsp_rpm_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_target_fan_index = rsp_idx_ff;
   assign rsp_rpm_target       = rsp_rpm_ff;
   assign rsp_fan_level        = rsp_level_ff;

   `FLHT_ASSERT_ALL(a_level_clamped, clock,
      (state_ff == ST_IDLE) |-> (int'(level_ff) < LEVEL_COUNT),
      "level above the top row while idle")
   `FLHT_ASSERT_RST(a_unpowered_skip, clock, reset,
      (req_valid && req_ready && !req_system_powered) |=> (state_ff == ST_IDLE),
      "unpowered word started an update")
   `FLHT_ASSERT_RST(a_rsp_from_done, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE),
      "result word raised outside the finish step")

endmodule

### dv/fan_level_hysteresis_table_tb.sv
// Self-checking testbench for the fan level hysteresis table controller.
module fan_level_hysteresis_table_tb;
   import fhyst_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 16;
   localparam int TEMP_MIN        = -128;
   localparam int TEMP_MAX        = 255;

   typedef struct {
      logic                   fan_index;
      logic [RPM_W-1:0]       rpm;
      logic [LEVEL_OUT_W-1:0] level;
   } fan_speed_word_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_system_powered;
   logic req_fan_index;
   logic signed [TEMP_W-1:0] req_temp_fan_zone;
   logic signed [TEMP_W-1:0] req_temp_soc;
   logic signed [TEMP_W-1:0] req_temp_charger;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_target_fan_index;
   logic [RPM_W-1:0] rsp_rpm_target;
   logic [LEVEL_OUT_W-1:0] rsp_fan_level;

   fan_speed_word_type speed_targets_due [$];
   bit mismatch_seen = 1'b0;
   bit idle_on = 1'b0;
   bit rsp_hold_req = 1'b0;

   // Thresholds and speeds per level: fan zone, SoC, charger.
   int on_fz   [7] = '{53, 54, 55, 56, 57, 58, 100};
   int on_soc  [7] = '{51, 52, 53, 54, 55, 56, 100};
   int on_chg  [7] = '{0, 0, 0, 0, 54, 60, 100};
   int off_fz  [7] = '{99, 52, 53, 54, 55, 56, 57};
   int off_soc [7] = '{99, 50, 51, 52, 53, 54, 59};
   int off_chg [7] = '{99, 99, 99, 99, 51, 52, 58};
   int speed_rpm [7] = '{0, 3000, 3400, 3800, 4100, 4400, 4900};

   int fan_level_now;
   int last_temp [3];
   int walk_temp [3];

   fan_level_hysteresis_table dut (.*);

   always #6 clock = ~clock;

   function automatic int row_of(input int lvl);
      return (lvl < 7) ? lvl : 6;
   endfunction

   // Moves the fan level for one powered sample and returns the word it produces.
   function automatic fan_speed_word_type advance_fan_level(input bit idx, input int t_fz,
                                                            input int t_soc, input int t_chg);
      fan_speed_word_type w;
      bit fell;
      bit rose;
      int r;
      fell = (t_fz < last_temp[0]) || (t_soc < last_temp[1]) || (t_chg < last_temp[2]);
      rose = (t_fz > last_temp[0]) || (t_soc > last_temp[1]) || (t_chg > last_temp[2]);
      if (fell) begin
         while (fan_level_now > 0) begin
            r = row_of(fan_level_now);
            if (t_fz < off_fz[r] && t_soc < off_soc[r] && t_chg < off_chg[r])
               fan_level_now--;
            else
               break;
         end
      end else if (rose) begin
         while (fan_level_now < LEVEL_COUNT) begin
            r = row_of(fan_level_now);
            if ((t_fz > on_fz[r] && t_chg > on_chg[r]) || t_soc > on_soc[r])
               fan_level_now++;
            else
               break;
         end
      end
      if (fan_level_now >= LEVEL_COUNT)
         fan_level_now = LEVEL_COUNT - 1;
      last_temp[0] = t_fz;
      last_temp[1] = t_soc;
      last_temp[2] = t_chg;
      w.fan_index = idx;
      w.rpm = RPM_W'(speed_rpm[row_of(fan_level_now)]);
      w.level = LEVEL_OUT_W'(fan_level_now);
      return w;
   endfunction

   // Mostly no gap, some short ones and a rare long one.
   function automatic int pick_gap();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int clamp_temp(input int t);
      return (t < TEMP_MIN) ? TEMP_MIN : (t > TEMP_MAX) ? TEMP_MAX : t;
   endfunction

   function automatic int rand_temp();
      return int'($urandom_range(0, 383)) - 128;
   endfunction

   // Valid stays high across back-to-back words; it is only lowered when a gap follows.
   task automatic send_sample(input bit powered, input bit idx, input int t_fz,
                              input int t_soc, input int t_chg);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_system_powered <= powered;
      req_fan_index      <= idx;
      req_temp_fan_zone  <= TEMP_W'(t_fz);
      req_temp_soc       <= TEMP_W'(t_soc);
      req_temp_charger   <= TEMP_W'(t_chg);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (powered)
         speed_targets_due.push_back(advance_fan_level(idx, t_fz, t_soc, t_chg));
   endtask

   // Powered samples mostly drift a few degrees around the thresholds.
   task automatic send_random_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         send_sample(1'b0, 1'($urandom_range(0, 1)), rand_temp(), rand_temp(), rand_temp());
         return;
      end else if (r < 15) begin
         for (int k = 0; k < 3; k++) walk_temp[k] = rand_temp();
      end else if (r < 22) begin
         for (int k = 0; k < 3; k++) walk_temp[k] = int'($urandom_range(30, 110));
      end else if (r >= 30) begin
         for (int k = 0; k < 3; k++)
            walk_temp[k] = clamp_temp(walk_temp[k] + int'($urandom_range(0, 8)) - 4);
      end
      send_sample(1'b1, 1'($urandom_range(0, 1)), walk_temp[0], walk_temp[1], walk_temp[2]);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (speed_targets_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      idle_on = 1'b0;
      send_sample(1'b0, 1'b0, 255, 255, 255);
      send_sample(1'b1, 1'b0, 0, 0, 0);
      send_sample(1'b1, 1'b1, 53, 51, 0);
      send_sample(1'b1, 1'b0, 54, 51, 1);
      send_sample(1'b1, 1'b0, 60, 51, 1);
      send_sample(1'b1, 1'b1, 60, 57, 1);
      send_sample(1'b1, 1'b0, 255, 255, 255);
      send_sample(1'b1, 1'b0, 255, 255, 255);
      send_sample(1'b0, 1'b1, -128, -128, -128);
      send_sample(1'b1, 1'b0, 255, 254, 255);
      send_sample(1'b1, 1'b1, 56, 58, 57);
      send_sample(1'b1, 1'b0, -128, -128, -128);
      send_sample(1'b1, 1'b0, -128, -128, -128);
      send_sample(1'b1, 1'b1, -1, -1, -1);
      send_sample(1'b1, 1'b0, 100, 101, 100);
      send_sample(1'b1, 1'b0, 100, -128, 255);
      send_sample(1'b1, 1'b1, 0, 0, 0);
      send_sample(1'b0, 1'b0, 0, 0, 0);
      send_sample(1'b1, 1'b1, 170, 85, -86);
      send_sample(1'b1, 1'b0, 58, 56, 61);
      drain_results();
   endtask

   task automatic test_random_walk(input int count, input bit with_idle);
      idle_on = with_idle;
      for (int k = 0; k < 3; k++) walk_temp[k] = 50;
      repeat (count) send_random_sample();
      drain_results();
   endtask

   // The receiver stops for a long stretch while words keep coming, so the input stalls.
   task automatic test_output_backpressure();
      idle_on = 1'b0;
      rsp_hold_req = 1'b1;
      repeat (40) send_random_sample();
      drain_results();
   endtask

   initial begin : rsp_ready_driver
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            stall_left = RSP_HOLD_CYCLES;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : speed_target_check
      fan_speed_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (speed_targets_due.size() == 0) begin
            $error("unexpected speed word: index %0d rpm %0d level %0d",
                   rsp_target_fan_index, rsp_rpm_target, rsp_fan_level);
            mismatch_seen = 1'b1;
         end else begin
            want = speed_targets_due.pop_front();
            if (rsp_target_fan_index !== want.fan_index) begin
               $error("target_fan_index: expected %0d, got %0d",
                      want.fan_index, rsp_target_fan_index);
               mismatch_seen = 1'b1;
            end
            if (rsp_rpm_target !== want.rpm) begin
               $error("rpm_target: expected %0d, got %0d", want.rpm, rsp_rpm_target);
               mismatch_seen = 1'b1;
            end
            if (rsp_fan_level !== want.level) begin
               $error("fan_level: expected %0d, got %0d", want.level, rsp_fan_level);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("** fan_level_hysteresis_table: FAILED **");
      $finish;
   end

   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_system_powered <= 1'b0;
      req_fan_index      <= 1'b0;
      req_temp_fan_zone  <= '0;
      req_temp_soc       <= '0;
      req_temp_charger   <= '0;
      fan_level_now = 0;
      for (int k = 0; k < 3; k++) last_temp[k] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_walk(900, 1'b1);
      test_output_backpressure();
      test_random_walk(300, 1'b0);
      if (!mismatch_seen)
         $display("** fan_level_hysteresis_table: PASSED **");
      else
         $display("** fan_level_hysteresis_table: FAILED **");
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/fhyst_pkg.sv
hdl/fhyst_cmp.sv
hdl/fan_level_hysteresis_table.sv
dv/fan_level_hysteresis_table_tb.sv
